// ----- hdl/nps_pkg.sv -----
// Package for the non-preemptive priority scheduler.
// Holds the item types of both channels, the field widths and the selection flags.
// No dependencies.
`default_nettype none

package nps_pkg;

  localparam int IN_TIME_W = 16;
  localparam int PRI_W     = 8;
  localparam int JOBNUM_W  = 5;
  localparam int OUT_TIME_W = 21;
  localparam int SUM_W     = 25;

  typedef struct packed {
    logic [IN_TIME_W-1:0] arrival_time;
    logic [IN_TIME_W-1:0] burst_time;
    logic [PRI_W-1:0]     job_priority;
    logic                 last_item;
  } job_item_t;

  typedef struct packed {
    logic [JOBNUM_W-1:0]   job_number;
    logic [OUT_TIME_W-1:0] wait_time;
    logic [OUT_TIME_W-1:0] turnaround;
    logic [SUM_W-1:0]      total_wait;
    logic [SUM_W-1:0]      total_turnaround;
    logic                  last_result;
  } result_item_t;

  typedef struct packed {
    logic ready_wins;
    logic early_wins;
  } sel_flags_t;

endpackage

`default_nettype wire

// ----- hdl/nps_job_store.sv -----
// Job table memory: one write port for loading, one registered read port for scanning.
// No dependencies.
`default_nettype none

module nps_job_store #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 40
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ----- hdl/nps_select_unit.sv -----
// Shared compare unit: tests one scanned job against the best ready job and the
// best earliest-arriving job found so far. Depends on nps_pkg.
`default_nettype none

module nps_select_unit import nps_pkg::*; #(
  parameter int TIME_WIDTH = 16,
  parameter int CLK_W      = 25
) (
  input  wire logic                  cand_live,
  input  wire logic [TIME_WIDTH-1:0] cand_arr,
  input  wire logic [PRI_W-1:0]      cand_pri,
  input  wire logic [CLK_W-1:0]      sim_clock,
  input  wire logic                  rb_vld,
  input  wire logic [TIME_WIDTH-1:0] rb_arr,
  input  wire logic [PRI_W-1:0]      rb_pri,
  input  wire logic                  eb_vld,
  input  wire logic [TIME_WIDTH-1:0] eb_arr,
  input  wire logic [PRI_W-1:0]      eb_pri,
  output sel_flags_t                 flags
);

  logic is_ready;
  logic beats_ready;
  logic beats_early;

  always_comb begin
    is_ready    = CLK_W'(cand_arr) <= sim_clock;
    beats_ready = (cand_pri < rb_pri) || ((cand_pri == rb_pri) && (cand_arr < rb_arr));
    beats_early = (cand_arr < eb_arr) || ((cand_arr == eb_arr) && (cand_pri < eb_pri));
    flags.ready_wins = cand_live && is_ready && (!rb_vld || beats_ready);
    flags.early_wins = cand_live && (!eb_vld || beats_early);
  end

endmodule

`default_nettype wire

// ----- hdl/nonpreemptive_priority_scheduler.sv -----
// Non-preemptive priority scheduler, top level. Depends on nps_pkg, nps_job_store, nps_select_unit.
// While loading, job_ready stays high, so jobs can be taken back to back. After the final job,
// each dispatch scans the n loaded jobs through the single table read port, then passes the
// drain and commit states; the next scan starts once the offered result is taken.
// No job is taken while a set is being dispatched. Reset empties the table; the
// stored job fields stay undefined until written.
`default_nettype none

module nonpreemptive_priority_scheduler import nps_pkg::*; #(
  parameter int MAX_PROCS  = 16,
  parameter int TIME_WIDTH = 16
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   job_valid,
  output logic        job_ready,
  input  wire job_item_t job,
  output logic        result_valid,
  input  wire logic   result_ready,
  output result_item_t result
);

  localparam int IDX_W  = $clog2(MAX_PROCS);
  localparam int CNT_W  = $clog2(MAX_PROCS + 1);
  localparam int ROW_W  = 2 * TIME_WIDTH + PRI_W;
  localparam int WIDE_W = TIME_WIDTH + IDX_W + 1;
  localparam int CLK_W  = (WIDE_W > SUM_W) ? WIDE_W : SUM_W;

  typedef enum logic [2:0] {
    S_LOAD,
    S_SCAN,
    S_DRAIN,
    S_COMMIT,
    S_OUT
  } state_t;

  state_t                state;
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      emit_cnt;
  logic [IDX_W-1:0]      scan_idx;
  logic                  rd_vld;
  logic [IDX_W-1:0]      rd_idx;
  logic                  done_marks [MAX_PROCS];
  logic [CLK_W-1:0]      sim_clock;
  logic [SUM_W-1:0]      wait_sum;
  logic [SUM_W-1:0]      tat_sum;

  logic                  rb_vld;
  logic [IDX_W-1:0]      rb_idx;
  logic [TIME_WIDTH-1:0] rb_arr;
  logic [TIME_WIDTH-1:0] rb_bur;
  logic [PRI_W-1:0]      rb_pri;
  logic                  eb_vld;
  logic [IDX_W-1:0]      eb_idx;
  logic [TIME_WIDTH-1:0] eb_arr;
  logic [TIME_WIDTH-1:0] eb_bur;
  logic [PRI_W-1:0]      eb_pri;

  logic                  wr_en;
  logic [ROW_W-1:0]      wr_data;
  logic [ROW_W-1:0]      rd_data;
  logic [TIME_WIDTH-1:0] rd_arr;
  logic [TIME_WIDTH-1:0] rd_bur;
  logic [PRI_W-1:0]      rd_pri;
  logic                  cand_live;
  sel_flags_t            flags;

  logic                  load_end;
  logic                  scan_last;
  logic [IDX_W-1:0]      pick_idx;
  logic [TIME_WIDTH-1:0] pick_arr;
  logic [TIME_WIDTH-1:0] pick_bur;
  logic [CLK_W-1:0]      clk_eff;
  logic [SUM_W-1:0]      w25;
  logic [SUM_W-1:0]      t25;
  logic [SUM_W-1:0]      wait_sum_next;
  logic [SUM_W-1:0]      tat_sum_next;
  logic                  is_last;

  assign job_ready = (state == S_LOAD);
  assign wr_en     = job_valid && job_ready;
  assign wr_data   = {TIME_WIDTH'(32'(job.arrival_time)), TIME_WIDTH'(32'(job.burst_time)),
                      job.job_priority};
  assign load_end  = job.last_item || (count == CNT_W'(MAX_PROCS - 1));
  assign scan_last = (scan_idx == IDX_W'(count - CNT_W'(1)));

  assign rd_arr    = rd_data[ROW_W-1 -: TIME_WIDTH];
  assign rd_bur    = rd_data[PRI_W +: TIME_WIDTH];
  assign rd_pri    = rd_data[PRI_W-1:0];
  assign cand_live = rd_vld && !done_marks[rd_idx];

  nps_job_store #(
    .DEPTH(MAX_PROCS),
    .WIDTH(ROW_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count[IDX_W-1:0]),
    .wr_data (wr_data),
    .rd_addr (scan_idx),
    .rd_data (rd_data)
  );

  nps_select_unit #(
    .TIME_WIDTH(TIME_WIDTH),
    .CLK_W     (CLK_W)
  ) u_select (
    .cand_live (cand_live),
    .cand_arr  (rd_arr),
    .cand_pri  (rd_pri),
    .sim_clock (sim_clock),
    .rb_vld    (rb_vld),
    .rb_arr    (rb_arr),
    .rb_pri    (rb_pri),
    .eb_vld    (eb_vld),
    .eb_arr    (eb_arr),
    .eb_pri    (eb_pri),
    .flags     (flags)
  );

  always_comb begin
    pick_idx      = rb_vld ? rb_idx : eb_idx;
    pick_arr      = rb_vld ? rb_arr : eb_arr;
    pick_bur      = rb_vld ? rb_bur : eb_bur;
    clk_eff       = rb_vld ? sim_clock : CLK_W'(eb_arr);
    w25           = SUM_W'(clk_eff - CLK_W'(pick_arr));
    t25           = w25 + SUM_W'(pick_bur);
    wait_sum_next = wait_sum + w25;
    tat_sum_next  = tat_sum + t25;
    is_last       = (CNT_W'(emit_cnt + CNT_W'(1)) == count);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_LOAD;
      count        <= '0;
      emit_cnt     <= '0;
      scan_idx     <= '0;
      rd_vld       <= 1'b0;
      rb_vld       <= 1'b0;
      eb_vld       <= 1'b0;
      result_valid <= 1'b0;
      sim_clock    <= '0;
      wait_sum     <= '0;
      tat_sum      <= '0;
      for (int i = 0; i < MAX_PROCS; i++) begin
        done_marks[i] <= 1'b0;
      end
    end else begin
      rd_vld <= (state == S_SCAN);
      rd_idx <= scan_idx;

      if (flags.ready_wins) begin
        rb_vld <= 1'b1;
        rb_idx <= rd_idx;
        rb_arr <= rd_arr;
        rb_bur <= rd_bur;
        rb_pri <= rd_pri;
      end
      if (flags.early_wins) begin
        eb_vld <= 1'b1;
        eb_idx <= rd_idx;
        eb_arr <= rd_arr;
        eb_bur <= rd_bur;
        eb_pri <= rd_pri;
      end

      case (state)
        S_LOAD: begin
          if (wr_en) begin
            done_marks[count[IDX_W-1:0]] <= 1'b0;
            count <= CNT_W'(count + CNT_W'(1));
            if (load_end) begin
              state     <= S_SCAN;
              scan_idx  <= '0;
              emit_cnt  <= '0;
              sim_clock <= '0;
              wait_sum  <= '0;
              tat_sum   <= '0;
              rb_vld    <= 1'b0;
              eb_vld    <= 1'b0;
            end
          end
        end
        S_SCAN: begin
          if (scan_last) begin
            state <= S_DRAIN;
          end else begin
            scan_idx <= IDX_W'(scan_idx + IDX_W'(1));
          end
        end
        S_DRAIN: begin
          state <= S_COMMIT;
        end
        S_COMMIT: begin
          sim_clock                   <= clk_eff + CLK_W'(pick_bur);
          wait_sum                    <= wait_sum_next;
          tat_sum                     <= tat_sum_next;
          done_marks[pick_idx]        <= 1'b1;
          result.job_number           <= JOBNUM_W'(32'(pick_idx) + 32'd1);
          result.wait_time            <= OUT_TIME_W'(w25);
          result.turnaround           <= OUT_TIME_W'(t25);
          result.total_wait           <= is_last ? wait_sum_next : '0;
          result.total_turnaround     <= is_last ? tat_sum_next : '0;
          result.last_result          <= is_last;
          result_valid                <= 1'b1;
          state                       <= S_OUT;
        end
        S_OUT: begin
          if (result_ready) begin
            result_valid <= 1'b0;
            if (result.last_result) begin
              state <= S_LOAD;
              count <= '0;
              for (int i = 0; i < MAX_PROCS; i++) begin
                done_marks[i] <= 1'b0;
              end
            end else begin
              state    <= S_SCAN;
              emit_cnt <= CNT_W'(emit_cnt + CNT_W'(1));
              scan_idx <= '0;
              rb_vld   <= 1'b0;
              eb_vld   <= 1'b0;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  a_no_load_during_output: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !job_ready)
    else $error("job accepted while a result is pending");

  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_PROCS))
    else $error("job count beyond table size");

  a_commit_has_pick: assert property (@(posedge clk) disable iff (rst)
    (state == S_COMMIT) |-> (rb_vld || eb_vld))
    else $error("dispatch without a selected job");

  a_set_done_empties: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_ready && result.last_result) |=> (job_ready && count == '0))
    else $error("table not emptied after final result");

endmodule

`default_nettype wire

// ----- tb/nps_dispatch_checker.sv -----
`timescale 1ns / 100ps
// Scoreboard for the non-preemptive priority scheduler. It watches both channels,
// predicts the dispatch order and times of every job set and compares each result item.
// Depends on nps_pkg.
module nps_dispatch_checker import nps_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         job_valid,
  input  logic         job_ready,
  input  job_item_t    job,
  input  logic         result_valid,
  input  logic         result_ready,
  input  result_item_t result,
  output int           mismatches,
  output int           pending
);

  localparam int TABLE_DEPTH = 16;
  localparam int REPORT_LIMIT = 10;

  logic [IN_TIME_W-1:0] arrival_tab [TABLE_DEPTH];
  logic [IN_TIME_W-1:0] burst_tab [TABLE_DEPTH];
  logic [PRI_W-1:0]     priority_tab [TABLE_DEPTH];
  int                   jobs_loaded;
  result_item_t         dispatch_q [$];

  function automatic bit runs_ahead(int a, int b);
    if (priority_tab[a] != priority_tab[b]) return priority_tab[a] < priority_tab[b];
    if (arrival_tab[a] != arrival_tab[b]) return arrival_tab[a] < arrival_tab[b];
    return a < b;
  endfunction

  task automatic dispatch_set();
    bit              served [TABLE_DEPTH];
    longint unsigned now;
    longint unsigned wait_acc;
    longint unsigned turn_acc;
    longint unsigned waited;
    longint unsigned turned;
    longint unsigned earliest;
    int              pick;
    int              number;
    int              i;
    int              k;
    result_item_t    r;
    now = 0;
    wait_acc = 0;
    turn_acc = 0;
    for (i = 0; i < TABLE_DEPTH; i++) served[i] = 1'b0;
    for (k = 0; k < jobs_loaded; k++) begin
      pick = -1;
      earliest = 64'hFFFF_FFFF_FFFF_FFFF;
      for (i = 0; i < jobs_loaded; i++) begin
        if (!served[i]) begin
          if (arrival_tab[i] < earliest) earliest = arrival_tab[i];
          if (arrival_tab[i] <= now && (pick < 0 || runs_ahead(i, pick))) pick = i;
        end
      end
      // Nothing has arrived yet, so the clock skips ahead to the next arrival.
      if (pick < 0) begin
        now = earliest;
        for (i = 0; i < jobs_loaded; i++) begin
          if (!served[i] && arrival_tab[i] <= now && (pick < 0 || runs_ahead(i, pick))) begin
            pick = i;
          end
        end
      end
      waited = now - arrival_tab[pick];
      turned = waited + burst_tab[pick];
      now += burst_tab[pick];
      served[pick] = 1'b1;
      wait_acc += waited;
      turn_acc += turned;
      number = pick + 1;
      r = '0;
      r.job_number = number[JOBNUM_W-1:0];
      r.wait_time = waited[OUT_TIME_W-1:0];
      r.turnaround = turned[OUT_TIME_W-1:0];
      if (k == jobs_loaded - 1) begin
        r.total_wait = wait_acc[SUM_W-1:0];
        r.total_turnaround = turn_acc[SUM_W-1:0];
        r.last_result = 1'b1;
      end
      dispatch_q.push_back(r);
    end
    jobs_loaded = 0;
  endtask

  task automatic report(string what, result_item_t exp, result_item_t act);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) begin
      $display("mismatch (%s) at %0t:", what, $realtime);
      $display("  expected job %0d wait %0d turnaround %0d totals %0d/%0d last %0b",
               exp.job_number, exp.wait_time, exp.turnaround,
               exp.total_wait, exp.total_turnaround, exp.last_result);
      $display("  got      job %0d wait %0d turnaround %0d totals %0d/%0d last %0b",
               act.job_number, act.wait_time, act.turnaround,
               act.total_wait, act.total_turnaround, act.last_result);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      jobs_loaded = 0;
      dispatch_q.delete();
    end else begin
      if (result_valid && result_ready) begin
        if (dispatch_q.size() == 0) begin
          report("unexpected item", '0, result);
        end else if (result.job_number !== dispatch_q[0].job_number ||
                     result.wait_time !== dispatch_q[0].wait_time ||
                     result.turnaround !== dispatch_q[0].turnaround ||
                     result.total_wait !== dispatch_q[0].total_wait ||
                     result.total_turnaround !== dispatch_q[0].total_turnaround ||
                     result.last_result !== dispatch_q[0].last_result) begin
          report("wrong field", dispatch_q[0], result);
          void'(dispatch_q.pop_front());
        end else begin
          void'(dispatch_q.pop_front());
        end
      end
      if (job_valid && job_ready) begin
        arrival_tab[jobs_loaded] = job.arrival_time;
        burst_tab[jobs_loaded] = job.burst_time;
        priority_tab[jobs_loaded] = job.job_priority;
        jobs_loaded++;
        if (job.last_item || jobs_loaded == TABLE_DEPTH) dispatch_set();
      end
    end
    pending = dispatch_q.size();
  end

endmodule

// ----- tb/tb_nonpreemptive_priority_scheduler.sv -----
`timescale 1ns / 100ps
// Testbench top for the non-preemptive priority scheduler: drives job sets and result
// back-pressure and gives the verdict. Depends on nps_pkg, the scheduler and nps_dispatch_checker.
module tb_nonpreemptive_priority_scheduler;
  import nps_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;
  localparam int ITEMS_PER_PHASE = 22;
  localparam int SETTLE_CYCLES = 60;

  logic         clk = 1'b0;
  logic         rst;
  logic         job_valid;
  logic         job_ready;
  job_item_t    job;
  logic         result_valid;
  logic         result_ready;
  result_item_t result;
  int           mismatches;
  int           pending;
  int           send_idle;
  int           stall_pct;
  bit           hold_request;

  always #2 clk = ~clk;

  nonpreemptive_priority_scheduler dut (
    .clk,
    .rst,
    .job_valid,
    .job_ready,
    .job,
    .result_valid,
    .result_ready,
    .result
  );

  nps_dispatch_checker scoreboard (
    .clk,
    .rst,
    .job_valid,
    .job_ready,
    .job,
    .result_valid,
    .result_ready,
    .result,
    .mismatches,
    .pending
  );

  function automatic job_item_t make_job(logic [15:0] arrival, logic [15:0] burst,
                                         logic [7:0] prio, logic last);
    job_item_t j;
    j.arrival_time = arrival;
    j.burst_time = burst;
    j.job_priority = prio;
    j.last_item = last;
    return j;
  endfunction

  function automatic job_item_t random_job(int style, logic last);
    job_item_t j;
    case (style)
      0: begin
        j.arrival_time = 16'($urandom_range(15, 0));
        j.burst_time = 16'($urandom_range(9, 0));
        j.job_priority = 8'($urandom_range(3, 0));
      end
      1: begin
        j.arrival_time = 16'($urandom);
        j.burst_time = 16'($urandom);
        j.job_priority = 8'($urandom);
      end
      default: begin
        j.arrival_time = 16'($urandom_range(200, 0));
        case ($urandom_range(3, 0))
          0: j.burst_time = 16'h0000;
          1: j.burst_time = 16'hFFFF;
          default: j.burst_time = 16'($urandom);
        endcase
        j.job_priority = 8'($urandom);
      end
    endcase
    j.last_item = last;
    return j;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance with valid still high.
  task automatic push_job(job_item_t item);
    while (send_idle > 0 && $urandom_range(99, 0) < send_idle) begin
      job_valid <= 1'b0;
      @(negedge clk);
    end
    job_valid <= 1'b1;
    job <= item;
    do @(posedge clk); while (!job_ready);
    @(negedge clk);
  endtask

  task automatic send_random_set(int set_size);
    int   style;
    int   i;
    logic last;
    style = $urandom_range(2, 0);
    for (i = 0; i < set_size; i++) begin
      if (i != set_size - 1) last = 1'b0;
      else if (set_size == 16) last = 1'($urandom_range(1, 0));
      else last = 1'b1;
      push_job(random_job(style, last));
    end
  endtask

  task automatic drain_results();
    job_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin : receiver
    int k;
    result_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        result_ready <= 1'b0;
        for (k = 0; k < HOLD_CYCLES; k++) @(negedge clk);
        hold_request = 1'b0;
      end else begin
        result_ready <= ($urandom_range(99, 0) >= stall_pct);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (job_valid && job_ready) || (result_valid && result_ready)) quiet = 0;
      else quiet++;
    end
    $display("[nonpreemptive_priority_scheduler] ERROR");
    $finish;
  end

  initial begin : stimulus
    int i;
    int phase;
    int phase_items;
    int set_size;
    int pick;
    rst = 1'b1;
    job_valid = 1'b0;
    job = '0;
    send_idle = 0;
    stall_pct = 0;
    hold_request = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    push_job(make_job(16'h0000, 16'h0000, 8'h00, 1'b1));
    push_job(make_job(16'hFFFF, 16'hFFFF, 8'hFF, 1'b1));
    // Equal priority and arrival, so the loading order decides.
    push_job(make_job(16'd5, 16'd3, 8'd7, 1'b0));
    push_job(make_job(16'd5, 16'd2, 8'd7, 1'b0));
    push_job(make_job(16'd5, 16'd1, 8'd7, 1'b1));
    // Only the first job is ready at zero; the other two tie on priority.
    push_job(make_job(16'd0, 16'd10, 8'd9, 1'b0));
    push_job(make_job(16'd2, 16'd4, 8'd2, 1'b0));
    push_job(make_job(16'd1, 16'd1, 8'd2, 1'b1));
    // The clock has to skip ahead twice.
    push_job(make_job(16'd100, 16'd5, 8'd1, 1'b0));
    push_job(make_job(16'd3, 16'd2, 8'd200, 1'b1));
    // A full table ends the load without the last flag.
    for (i = 0; i < 16; i++) begin
      push_job(make_job((i % 3 == 0) ? 16'hFFFF : 16'h0000, 16'hFFFF, 8'(i % 4), 1'b0));
    end
    drain_results();

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle = 0; stall_pct = 0; end
        1: begin send_idle = 51; stall_pct = 0; end
        2: begin send_idle = 0; stall_pct = 51; end
        default: begin send_idle = 7; stall_pct = 7; end
      endcase
      if (phase == 0) begin
        // Hold results back while two full sets are offered, so the input stalls.
        hold_request = 1'b1;
        send_random_set(16);
        send_random_set(16);
        drain_results();
        @(negedge clk);
      end
      phase_items = 0;
      while (phase_items < ITEMS_PER_PHASE) begin
        pick = $urandom_range(9, 0);
        if (pick == 0) set_size = 16;
        else if (pick == 1) set_size = $urandom_range(15, 7);
        else set_size = $urandom_range(6, 1);
        send_random_set(set_size);
        phase_items += set_size;
      end
      drain_results();
      @(negedge clk);
    end

    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("[nonpreemptive_priority_scheduler] OK");
    end else begin
      $display("[nonpreemptive_priority_scheduler] ERROR");
    end
    $finish;
  end

endmodule
